@@ hw/rtl/stepper_segment_planner_unit_defines.svh @@
// assertion helpers for the stepper segment planner checker
// both expect clk_i and rst_ni in the scope where they are used
`ifndef STEPPER_SEGMENT_PLANNER_UNIT_DEFINES_SVH
`define STEPPER_SEGMENT_PLANNER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ssp_pkg.sv @@
package ssp_pkg;

  // field widths
  localparam int unsigned POS_W    = 32;
  localparam int unsigned ERR_W    = 16;
  localparam int unsigned PER_W    = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned STEP_W   = 24;
  localparam int unsigned SEG_W    = 24;
  localparam int unsigned MINC_W   = 15;
  localparam int unsigned DVD_W    = SEG_W + 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 72;

  // period decision limits on the quotient
  localparam logic [STEP_W-1:0] SLOW_LIMIT = 24'h007fff;
  localparam logic [STEP_W-1:0] STOP_LIMIT = 24'h00ffff;
  localparam logic [PER_W-1:0]  PER_MAX    = 16'hffff;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_CLK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CORR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PER  = 3'd4;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_PREP = 2'd1,
    OP_LOAD = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NOT_PREP    = 2'd1,
    STAT_ALREADY_PREP = 2'd2
  } status_e;

  // request to the serial divider
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [STEP_W-1:0] divisor;
  } div_req_t;

endpackage

@@ hw/rtl/ssp_div.sv @@
module ssp_div import ssp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned ITER_W = $clog2(DVD_W);
  localparam logic [ITER_W-1:0] LAST = ITER_W'(DVD_W - 1);

  logic              busy_q;
  logic [ITER_W-1:0] cnt_q;
  logic [STEP_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0]  dvd_q;
  logic [STEP_W-1:0] dsr_q;
  logic [STEP_W:0]   shifted;
  logic [STEP_W+1:0] diff;
  logic              take;

  // one restoring step: bring in the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem_q, dvd_q[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    take    = ~diff[STEP_W+1];
    rem_d   = take ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
  end

  assign done_o = busy_q && (cnt_q == LAST);
  assign quot_o = dvd_q;

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  // dividend shifts out the top, quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DVD_W-2:0], take};
    end
  end

endmodule

@@ hw/rtl/stepper_segment_planner_unit.sv @@
// Move planner for one stepper motor. Each input item carries an operation
// in tuser (set position, prepare, load, or no operation) and returns exactly
// one result item with a status in tuser. Items are handled one at a time;
// prepare runs S_CORR, S_ABS, S_DIV and S_PER, where S_DIV waits for the
// bit-serial restoring divider that turns segment_clocks into a step period
// (one quotient bit per cycle over the 26-bit dividend 4*segment_clocks).
// S_OUT waits while an unread earlier result holds the output register. A
// finished result waits in that register, so the next item can be taken
// before the previous result is read. Configuration writes are to be made
// only when no item is in flight; the block does not enforce this. Register
// indexes 0..4 are motor_enabled, reverse_polarity, segment_clocks,
// min_correction and min_period, other indexes are ignored.
module stepper_segment_planner_unit import ssp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input item
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // target_steps [31:0], counted_steps [47:32]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]            s_axis_tuser,
  // result item
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // step_period [15:0], clock_fast [16], direction [17], running [18],
  // encoder_count [50:19], following_error [66:51], zero [71:67]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0]            m_axis_tuser,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_CORR  = 4'd2;
  localparam logic [3:0] S_ABS   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_PER   = 4'd5;
  localparam logic [3:0] S_ERR   = 4'd6;
  localparam logic [3:0] S_START = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // saturate 33-bit two's complement to 24 bits
  function automatic logic [STEP_W-1:0] sat_33_24(input logic [POS_W:0] v);
    logic same;
    same = (&v[POS_W:STEP_W-1]) | ~(|v[POS_W:STEP_W-1]);
    if (same) return v[STEP_W-1:0];
    return v[POS_W] ? {1'b1, {(STEP_W-1){1'b0}}} : {1'b0, {(STEP_W-1){1'b1}}};
  endfunction

  // saturate 25-bit two's complement to 24 bits
  function automatic logic [STEP_W-1:0] sat_25_24(input logic [STEP_W:0] v);
    if (v[STEP_W] == v[STEP_W-1]) return v[STEP_W-1:0];
    return v[STEP_W] ? {1'b1, {(STEP_W-1){1'b0}}} : {1'b0, {(STEP_W-1){1'b1}}};
  endfunction

  // saturate 33-bit two's complement to 16 bits
  function automatic logic [ERR_W-1:0] sat_33_16(input logic [POS_W:0] v);
    logic same;
    same = (&v[POS_W:ERR_W-1]) | ~(|v[POS_W:ERR_W-1]);
    if (same) return v[ERR_W-1:0];
    return v[POS_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
  endfunction

  // configuration
  logic              enabled_q, reverse_q;
  logic [SEG_W-1:0]  seg_clk_q;
  logic [MINC_W-1:0] min_corr_q;
  logic [PER_W-1:0]  min_per_q;

  // control and planner state
  logic [3:0]        state_q;
  op_e               op_q;
  status_e           status_q;
  logic [POS_W-1:0]  target_q, planned_q, commanded_q, encoder_q;
  logic [CNT_W-1:0]  counted_q;
  logic [ERR_W-1:0]  error_q;
  logic              move_neg_q, run_neg_q, prepared_q, fast_q, running_q;
  logic [PER_W-1:0]  period_q;
  logic [STEP_W-1:0] steps_q, n_q;

  // output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [1:0]            out_user_q;

  // datapath values
  logic [POS_W:0]    delta_wide, err_wide;
  logic [ERR_W-1:0]  err_abs;
  logic              corr_on;
  logic [STEP_W:0]   addend, corr_sum;
  logic [STEP_W-1:0] n_d;
  logic [POS_W-1:0]  enc_d;
  logic              out_free;

  // period decision from the quotient q = floor(4S/n)
  logic [DVD_W-1:0]  quot, quot_inc;
  logic              div_done;
  logic [STEP_W-1:0] q_s;
  logic [STEP_W:0]   q_2, q_2_inc;
  logic              use_fast;
  logic [PER_W-1:0]  per_d;
  div_req_t          div_req;

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = ~out_valid_q | m_axis_tready;

  always_comb begin
    delta_wide = {target_q[POS_W-1], target_q} - {planned_q[POS_W-1], planned_q};
    err_abs    = error_q[ERR_W-1] ? (~error_q + 1'b1) : error_q;
    corr_on    = {1'b0, min_corr_q} <= err_abs;
    addend     = error_q[ERR_W-1] ? (~{10'd0, err_abs[ERR_W-1:1]} + 1'b1)
                                  : {10'd0, err_abs[ERR_W-1:1]};
    corr_sum   = {steps_q[STEP_W-1], steps_q} + addend;
    n_d        = steps_q[STEP_W-1] ? (~steps_q + 1'b1) : steps_q;
    enc_d      = run_neg_q ? (encoder_q - {16'd0, counted_q})
                           : (encoder_q + {16'd0, counted_q});
    err_wide   = {commanded_q[POS_W-1], commanded_q} - {encoder_q[POS_W-1], encoder_q};
  end

  // divider launch while the step count is formed
  always_comb begin
    div_req.start    = (state_q == S_ABS);
    div_req.dividend = {seg_clk_q, 2'b00};
    div_req.divisor  = n_d;
  end

  ssp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  // clock choice, rounding, clamp and stop
  always_comb begin
    q_s      = quot[DVD_W-1:2];
    q_2      = quot[DVD_W-1:1];
    q_2_inc  = q_2 + 1'b1;
    quot_inc = quot + 1'b1;
    use_fast = q_s < SLOW_LIMIT;
    per_d    = '0;
    if (n_q == '0) begin
      per_d = '0;
    end else if (use_fast) begin
      if (q_2 < {9'd0, min_per_q}) per_d = min_per_q;
      else                         per_d = quot_inc[PER_W:1];
      if (per_d == PER_MAX) per_d = '0;
    end else if (q_s < STOP_LIMIT) begin
      per_d = q_2_inc[PER_W:1];
    end
    if (!enabled_q) per_d = '0;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      reverse_q  <= 1'b0;
      seg_clk_q  <= 24'd300000;
      min_corr_q <= 15'd2;
      min_per_q  <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ENABLE:   enabled_q  <= cfg_data_i[0];
        REG_REVERSE:  reverse_q  <= cfg_data_i[0];
        REG_SEG_CLK:  seg_clk_q  <= cfg_data_i[SEG_W-1:0];
        REG_MIN_CORR: min_corr_q <= cfg_data_i[MINC_W-1:0];
        REG_MIN_PER:  min_per_q  <= cfg_data_i[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q      <= op_e'(s_axis_tuser);
      target_q  <= s_axis_tdata[POS_W-1:0];
      counted_q <= s_axis_tdata[POS_W+CNT_W-1:POS_W];
    end
  end

  // working registers of a prepare
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_EXEC:  steps_q <= sat_33_24(delta_wide);
      S_CORR:  if (corr_on) steps_q <= sat_25_24(corr_sum);
      S_ABS:   n_q <= n_d;
      default: ;
    endcase
  end

  // sequencer and planner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= STAT_OK;
      planned_q   <= '0;
      commanded_q <= '0;
      encoder_q   <= '0;
      error_q     <= '0;
      move_neg_q  <= 1'b0;
      run_neg_q   <= 1'b0;
      prepared_q  <= 1'b0;
      period_q    <= '0;
      fast_q      <= 1'b0;
      running_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) state_q <= S_EXEC;
        end
        S_EXEC: begin
          case (op_q)
            OP_SET: begin
              status_q    <= STAT_OK;
              state_q     <= S_OUT;
              planned_q   <= target_q;
              commanded_q <= target_q;
              encoder_q   <= target_q;
              error_q     <= '0;
            end
            OP_PREP: begin
              if (prepared_q) begin
                status_q <= STAT_ALREADY_PREP;
                state_q  <= S_OUT;
              end else begin
                status_q  <= STAT_OK;
                planned_q <= target_q;
                state_q   <= S_CORR;
              end
            end
            OP_LOAD: begin
              if (!prepared_q) begin
                status_q <= STAT_NOT_PREP;
                state_q  <= S_OUT;
              end else begin
                status_q   <= STAT_OK;
                prepared_q <= 1'b0;
                if (running_q) begin
                  running_q <= 1'b0;
                  encoder_q <= enc_d;
                  state_q   <= S_ERR;
                end else begin
                  state_q <= S_START;
                end
              end
            end
            default: begin
              status_q <= STAT_OK;
              state_q  <= S_OUT;
            end
          endcase
        end
        S_CORR: state_q <= S_ABS;
        S_ABS: begin
          move_neg_q <= steps_q[STEP_W-1];
          state_q    <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state_q <= S_PER;
        end
        S_PER: begin
          period_q   <= per_d;
          fast_q     <= (per_d != '0) && use_fast;
          prepared_q <= 1'b1;
          if (!enabled_q) begin
            commanded_q <= planned_q;
            encoder_q   <= planned_q;
            error_q     <= '0;
          end
          state_q <= S_OUT;
        end
        S_ERR: begin
          error_q <= sat_33_16(err_wide);
          state_q <= S_START;
        end
        S_START: begin
          if (period_q != '0) begin
            running_q   <= 1'b1;
            run_neg_q   <= move_neg_q;
            commanded_q <= planned_q;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result snapshot
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_data_q <= {5'd0, error_q, encoder_q, running_q, move_neg_q ^ reverse_q,
                     fast_q, period_q};
      out_user_q <= status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ hw/rtl/ssp_chk.sv @@
`include "stepper_segment_planner_unit_defines.svh"

module ssp_chk import ssp_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]            m_axis_tuser
);

  // a stalled result item holds
  `SSP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result item changed while stalled")

  // a stopped step clock is never reported as fast
  `SSP_ASSERT_NOW(a_stop_not_fast, m_axis_tvalid && (m_axis_tdata[15:0] == 16'd0), !m_axis_tdata[16], "stopped clock flagged fast")

  // one item at a time: busy right after an accept
  `SSP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item accepted while busy")

  // a new result comes out of a busy cycle
  `SSP_ASSERT_NOW(a_result_from_work, $rose(m_axis_tvalid), !$past(s_axis_tready), "result appeared without work")

endmodule

bind stepper_segment_planner_unit ssp_chk u_ssp_chk (.*);
